>>> hdl/e2ra_pkg.sv
// ---------------------------------------------------------------------------
// e2ra_pkg: shared types and constants for the base-two exponential block
// Coefficients, field widths, status codes and cell payload types.
// ---------------------------------------------------------------------------
`default_nettype none
package e2ra_pkg;
   localparam int IN_FRAC_BITS  = 23;
   localparam int OUT_FRAC_BITS = 31;

   localparam logic [31:0] COEF_A   = 32'd1074074843;
   localparam logic [31:0] COEF_B   = 32'd14332794;
   localparam logic [31:0] COEF_ONE = 32'd16384;
   localparam logic [31:0] COEF_C   = 32'd3099124900;
   localparam logic [31:0] COEF_D   = 32'd165437692;
   localparam logic [31:0] COEF_E   = 32'd709471;

   localparam logic [1:0] ST_NORMAL = 2'd0;
   localparam logic [1:0] ST_OVER   = 2'd1;
   localparam logic [1:0] ST_UNDER  = 2'd2;

   // quotient bits produced by the divider chain
   localparam int QBITS = 33;

   typedef struct packed {
      logic [31:0] mantissa;
      logic [7:0]  exponent;
      logic [1:0]  status;
   } rsp_type;

   // state handed between divider cells
   typedef struct packed {
      logic        valid;
      logic [33:0] rem;
      logic [33:0] den;
      logic [QBITS-1:0] quo;
      logic [7:0]  exponent;
      logic [1:0]  status;
   } div_type;
endpackage
`default_nettype wire

>>> hdl/e2ra_if.sv
// ---------------------------------------------------------------------------
// e2ra_req_if / e2ra_rsp_if: valid-ready channels
// Carry the request argument and the result item.
// ---------------------------------------------------------------------------
`default_nettype none
interface e2ra_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_in;
   modport source (output valid, output x_in, input ready);
   modport sink   (input valid, input x_in, output ready);
endinterface

interface e2ra_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] mantissa;
   logic [7:0]  exponent;
   logic [1:0]  status;
   modport source (output valid, output mantissa, output exponent, output status,
                   input ready);
   modport sink   (input valid, input mantissa, input exponent, input status,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/e2ra_poly.sv
// ---------------------------------------------------------------------------
// e2ra_poly: argument split and rational polynomial pipeline
// Rounds x, forms |f| and evaluates num and den, up to two multiplies per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module e2ra_poly (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [31:0]             x_in,
   output e2ra_pkg::div_type            out
);
   function automatic logic [31:0] rnd(input logic [63:0] p);
      logic [64:0] t;
      t = {1'b0, p} + 65'h80000000;
      return t[63:32];
   endfunction

   // stage registers
   logic [4:0]  v_ff;
   logic [31:0] g1_ff, g2_ff, g3_ff, g4_ff;
   logic [31:0] s2_ff, s3_ff, s4_ff;
   logic [31:0] u3_ff, t3_ff, v4_ff, e4_ff, e5_ff, o5_ff;
   logic        n1_ff, n2_ff, n3_ff, n4_ff, n5_ff;
   logic [7:0]  x1_ff, x2_ff, x3_ff, x4_ff, x5_ff;
   logic [1:0]  c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;

   logic signed [31:0] xs;
   logic        xneg, fneg;
   logic [31:0] mag;
   logic [32:0] ip_sum;
   logic [8:0]  ip;
   logic signed [32:0] f;
   logic [31:0] fabs;
   logic [1:0]  st;
   logic [32:0] num, den;

   // split argument
   always_comb begin
      xs     = $signed(x_in);
      xneg   = xs[31];
      mag    = xneg ? (~x_in + 32'd1) : x_in;
      ip_sum = {1'b0, mag} + 33'(1 << (e2ra_pkg::IN_FRAC_BITS - 1));
      ip     = ip_sum[e2ra_pkg::IN_FRAC_BITS +: 9];
      f      = $signed({xs[31], xs}) - (xneg ? -$signed({1'b0, 32'(ip) <<
               e2ra_pkg::IN_FRAC_BITS}) : $signed({1'b0, 32'(ip) <<
               e2ra_pkg::IN_FRAC_BITS}));
      fneg   = f[32];
      fabs   = fneg ? 32'(-f) : f[31:0];
      if (xs >= $signed(32'(127) <<< e2ra_pkg::IN_FRAC_BITS)) st = e2ra_pkg::ST_OVER;
      else if (xs < -$signed(32'(128) <<< e2ra_pkg::IN_FRAC_BITS))
         st = e2ra_pkg::ST_UNDER;
      else st = e2ra_pkg::ST_NORMAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
      if (en) begin
         // split
         g1_ff <= fabs << (32 - e2ra_pkg::IN_FRAC_BITS);
         n1_ff <= fneg;
         x1_ff <= xneg ? 8'(-ip) : ip[7:0];
         c1_ff <= st;
         // square
         s2_ff <= rnd(64'(g1_ff) * 64'(g1_ff));
         g2_ff <= g1_ff; n2_ff <= n1_ff; x2_ff <= x1_ff; c2_ff <= c1_ff;
         // inner terms
         u3_ff <= e2ra_pkg::COEF_B + rnd(64'(s2_ff) * 64'(e2ra_pkg::COEF_ONE));
         t3_ff <= e2ra_pkg::COEF_D + rnd(64'(s2_ff) * 64'(e2ra_pkg::COEF_E));
         s3_ff <= s2_ff; g3_ff <= g2_ff; n3_ff <= n2_ff; x3_ff <= x2_ff;
         c3_ff <= c2_ff;
         // middle terms
         v4_ff <= e2ra_pkg::COEF_A + rnd(64'(s3_ff) * 64'(u3_ff));
         e4_ff <= e2ra_pkg::COEF_C + rnd(64'(s3_ff) * 64'(t3_ff));
         s4_ff <= s3_ff; g4_ff <= g3_ff; n4_ff <= n3_ff; x4_ff <= x3_ff;
         c4_ff <= c3_ff;
         // odd part
         o5_ff <= rnd(64'(g4_ff) * 64'(v4_ff));
         e5_ff <= e4_ff; n5_ff <= n4_ff; x5_ff <= x4_ff; c5_ff <= c4_ff;
      end
   end

   // form num and den, seed the divider
   always_comb begin
      num = n5_ff ? 33'(e5_ff) - 33'(o5_ff) : 33'(e5_ff) + 33'(o5_ff);
      den = n5_ff ? 33'(e5_ff) + 33'(o5_ff) : 33'(e5_ff) - 33'(o5_ff);
      out.valid    = v_ff[4];
      out.den      = {1'b0, den};
      // raw num; the top level aligns it for the first cell
      out.rem      = {1'b0, num};
      out.quo      = '0;
      out.exponent = x5_ff;
      out.status   = c5_ff;
   end
   logic unused;
   assign unused = ^{s4_ff, num[32], ip_sum[32:e2ra_pkg::IN_FRAC_BITS+9]};
endmodule
`default_nettype wire

>>> hdl/e2ra_div_cell.sv
// ---------------------------------------------------------------------------
// e2ra_div_cell: one restoring division step
// Shifts in one bit of the dividend and produces one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none
module e2ra_div_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              bit_in,
   input  e2ra_pkg::div_type      din,
   output e2ra_pkg::div_type      dout
);
   e2ra_pkg::div_type q_in, q_ff;
   logic [34:0] trial;

   // shift, trial subtract, pick
   always_comb begin
      q_in  = din;
      trial = {din.rem, bit_in} - {1'b0, din.den};
      if (!trial[34]) begin
         q_in.rem = trial[33:0];
         q_in.quo = {din.quo[e2ra_pkg::QBITS-2:0], 1'b1};
      end else begin
         q_in.rem = {din.rem[32:0], bit_in};
         q_in.quo = {din.quo[e2ra_pkg::QBITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff.valid <= din.valid;
      end
      if (en) begin
         q_ff.rem <= q_in.rem; q_ff.den <= q_in.den; q_ff.quo <= q_in.quo;
         q_ff.exponent <= q_in.exponent; q_ff.status <= q_in.status;
      end
   end
   assign dout = q_ff;
endmodule
`default_nettype wire

>>> hdl/exp2_rational_approx.sv
// ---------------------------------------------------------------------------
// exp2_rational_approx: base-two exponential, Q9.23 in, Q1.31 mantissa out
// Top level: polynomial pipeline, chain of divider cells, output register.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries x_in (signed Q9.23); rsp channel returns mantissa
//   (Q1.31), exponent (round half away from zero of x) and status
//   (normal, overflow saturated, underflow to zero).
//   A request enters every cycle while the chain is not held. The path is 5
//   polynomial stages, then one divider cell per quotient bit (33 cells, one
//   quotient bit each), then the output register. Throughput is one item per
//   cycle while the receiver does not stall, set by the cell chain which
//   advances all items together.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and req_ready drops; an empty output register lets the chain advance.
//   Synchronous reset clears all valid bits; no request is lost after it.
//   The cells produce q = floor(num*2^32/den); the mantissa is (q+1)/2,
//   which equals (num*2^31 + den/2)/den rounded down.
// ---------------------------------------------------------------------------
`default_nettype none
module exp2_rational_approx (
   input  wire logic     clock,
   input  wire logic     reset,
   e2ra_req_if.sink      req,
   e2ra_rsp_if.source    rsp
);
   localparam int NC = e2ra_pkg::OUT_FRAC_BITS + 2;

   logic en;
   e2ra_pkg::div_type chain [0:NC];
   e2ra_pkg::rsp_type out_in, out_ff;
   logic              ov_ff;
   logic [NC-1:0]     fbits;

   // advance whenever the output slot is free or being taken
   assign en        = !ov_ff || rsp.ready;
   assign req.ready = en;

   e2ra_poly u_poly (
      .clock, .reset, .en,
      .in_valid (req.valid), .x_in (req.x_in), .out (chain[0])
   );

   // load num>>1 as the remainder and shift num's low bit into the first
   // cell, so that cell compares num against den (num < 2*den) and yields
   // the integer bit; later cells shift in zeros for the fraction bits
   function automatic e2ra_pkg::div_type seed(input e2ra_pkg::div_type d);
      e2ra_pkg::div_type r;
      r = d;
      r.rem = {1'b0, d.rem[33:1]};
      return r;
   endfunction

   genvar i;
   generate
      for (i = 0; i < NC; i++) begin : g_cell
         e2ra_div_cell u_cell (
            .clock, .reset, .en, .bit_in (i == 0 ? chain[0].rem[0] : 1'b0),
            .din (i == 0 ? seed(chain[0]) : chain[i]), .dout (chain[i+1])
         );
      end
   endgenerate
   assign fbits = chain[NC].quo;

   // round to nearest: q = floor(num*2^32/den), mantissa = (q + 1) >> 1
   always_comb begin
      logic [33:0] qr;
      qr = {1'b0, fbits} + 34'd1;
      out_in.exponent = chain[NC].exponent;
      out_in.status   = chain[NC].status;
      unique case (chain[NC].status)
         e2ra_pkg::ST_OVER: begin
            out_in.mantissa = 32'hFFFFFFFF;
            out_in.exponent = 8'd127;
         end
         e2ra_pkg::ST_UNDER: begin
            out_in.mantissa = '0;
            out_in.exponent = '0;
         end
         default: out_in.mantissa = qr[32:1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= chain[NC].valid;
      end
      if (en) out_ff <= out_in;
   end

   assign rsp.valid    = ov_ff;
   assign rsp.mantissa = out_ff.mantissa;
   assign rsp.exponent = out_ff.exponent;
   assign rsp.status   = out_ff.status;
endmodule
`default_nettype wire

>>> test/exp2_rational_approx_tb.sv
// ---------------------------------------------------------------------------
// exp2_rational_approx_tb: self-checking bench for the base-two exponential
// Drives signed Q9.23 arguments through a valid-ready channel with random
// gaps and receiver stalls, and checks every result against a fixed-point
// model of the rounding, rational approximation and saturation behavior.
// ---------------------------------------------------------------------------
`default_nettype none
module exp2_rational_approx_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   logic clock;
   logic reset;

   e2ra_req_if req_ch ();
   e2ra_rsp_if rsp_ch ();

   exp2_rational_approx dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   logic [31:0]       pending_args[$];
   e2ra_pkg::rsp_type expected_results[$];
   int                error_count;
   int                idle_cycles;
   bit                calm_stretch;
   bit                hold_sender;
   bit                req_accepted;

   // Round half up after a 32-bit shift
   function automatic logic [63:0] round_q32(input logic [63:0] p);
      return (p + 64'h8000_0000) >> 32;
   endfunction

   // Predict 2^x as mantissa, exponent and status
   function automatic e2ra_pkg::rsp_type predict_exp2(input logic [31:0] arg);
      e2ra_pkg::rsp_type res;
      longint xs, one, n, f;
      logic [63:0] mag, ip, g, s, u, v, o, t, e, num, den;
      logic [95:0] quo;
      xs  = longint'(signed'(arg));
      one = longint'(1) << e2ra_pkg::IN_FRAC_BITS;
      if (xs >= 127 * one) begin
         res.mantissa = 32'hFFFF_FFFF;
         res.exponent = 8'd127;
         res.status   = e2ra_pkg::ST_OVER;
         return res;
      end
      if (xs < -128 * one) begin
         res.mantissa = '0;
         res.exponent = '0;
         res.status   = e2ra_pkg::ST_UNDER;
         return res;
      end
      mag = (xs < 0) ? 64'(-xs) : 64'(xs);
      ip  = (mag + (64'd1 << (e2ra_pkg::IN_FRAC_BITS - 1))) >> e2ra_pkg::IN_FRAC_BITS;
      n   = (xs < 0) ? -longint'(ip) : longint'(ip);
      f   = xs - n * one;
      g   = ((f < 0) ? 64'(-f) : 64'(f)) << (32 - e2ra_pkg::IN_FRAC_BITS);
      s   = round_q32(g * g);
      u   = 64'(e2ra_pkg::COEF_B) + round_q32(s * 64'(e2ra_pkg::COEF_ONE));
      v   = 64'(e2ra_pkg::COEF_A) + round_q32(s * u);
      o   = round_q32(g * v);
      t   = 64'(e2ra_pkg::COEF_D) + round_q32(s * 64'(e2ra_pkg::COEF_E));
      e   = 64'(e2ra_pkg::COEF_C) + round_q32(s * t);
      num = (f < 0) ? e - o : e + o;
      den = (f < 0) ? e + o : e - o;
      quo = ((96'(num) << e2ra_pkg::OUT_FRAC_BITS) + 96'(den >> 1)) / 96'(den);
      res.mantissa = quo[31:0];
      res.exponent = n[7:0];
      res.status   = e2ra_pkg::ST_NORMAL;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: present requests at the falling edge, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_accepted) begin
         // hold the request until accepted
      end else if (pending_args.size() != 0 && !hold_sender &&
                   (calm_stretch || $urandom_range(99) >= 14)) begin
         req_ch.valid <= 1'b1;
         req_ch.x_in  <= pending_args[0];
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_ch.ready <= reset ? 1'b0 : (calm_stretch || $urandom_range(99) >= 14);
   end

   // Monitor: record accepted requests, check accepted results
   always @(posedge clock) begin
      req_accepted <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_exp2(req_ch.x_in));
            void'(pending_args.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_ch.mantissa, '0);
            end else begin
               if (rsp_ch.mantissa !== expected_results[0].mantissa)
                  report_mismatch("mantissa", rsp_ch.mantissa,
                                  expected_results[0].mantissa);
               if (rsp_ch.exponent !== expected_results[0].exponent)
                  report_mismatch("exponent", 32'(rsp_ch.exponent),
                                  32'(expected_results[0].exponent));
               if (rsp_ch.status !== expected_results[0].status)
                  report_mismatch("status", 32'(rsp_ch.status),
                                  32'(expected_results[0].status));
               void'(expected_results.pop_front());
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      logic [31:0] r;
      int sel;
      error_count  = 0;
      idle_cycles  = 0;
      calm_stretch = 1'b0;
      hold_sender  = 1'b0;
      req_accepted = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.x_in  = '0;
      rsp_ch.ready = 1'b0;
      reset        = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, saturation borders, exact halves, zero
      pending_args.push_back(32'h8000_0000);
      pending_args.push_back(32'h7FFF_FFFF);
      pending_args.push_back(32'h0000_0000);
      pending_args.push_back(32'hFFFF_FFFF);
      pending_args.push_back(32'h0000_0001);
      pending_args.push_back(127 << 23);
      pending_args.push_back((127 << 23) - 1);
      pending_args.push_back(-(128 << 23));
      pending_args.push_back(-(128 << 23) - 1);
      pending_args.push_back(32'h0040_0000);
      pending_args.push_back(-32'sh0040_0000);
      pending_args.push_back(32'h0040_0000 + (5 << 23));
      pending_args.push_back(-32'sh0040_0000 - (5 << 23));
      pending_args.push_back(32'h003F_FFFF);
      pending_args.push_back(-32'sh003F_FFFF);
      pending_args.push_back(32'h0080_0000);
      pending_args.push_back(-32'sh0080_0000);
      pending_args.push_back((126 << 23) + 32'h0040_0000);
      pending_args.push_back(-(127 << 23) - 32'h0040_0000);
      pending_args.push_back(-(128 << 23) + 32'h0040_0000);

      // Pause the sender until every result is back
      wait (pending_args.size() == 0);
      hold_sender = 1'b1;
      wait (expected_results.size() == 0);
      hold_sender = 1'b0;

      // Random: mostly in range, some anywhere, some near the borders
      for (int i = 0; i < 1200; i++) begin
         sel = $urandom_range(9);
         r   = $urandom;
         if (sel < 6)
            r = 32'($urandom_range(255 << 23)) - (128 << 23);
         else if (sel == 6)
            r = (32'($urandom_range(255)) - 128) << 23 | 32'h0040_0000
                | ($urandom_range(1) ? 32'h0 : 32'h1);
         else if (sel == 7)
            r = ($urandom_range(1) ? (127 << 23) : -(128 << 23))
                + 32'($urandom_range(8)) - 4;
         pending_args.push_back(r);
         if (i == 400) begin
            wait (pending_args.size() < 10);
            calm_stretch = 1'b1;
         end
         if (i == 700) begin
            wait (pending_args.size() < 10);
            calm_stretch = 1'b0;
         end
      end

      wait (pending_args.size() == 0 && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> exp2_rational_approx.f
hdl/e2ra_pkg.sv
hdl/e2ra_if.sv
hdl/e2ra_poly.sv
hdl/e2ra_div_cell.sv
hdl/exp2_rational_approx.sv
test/exp2_rational_approx_tb.sv
